FILE: rtl/si_pkg.sv
// Shared types, widths and status codes for the segment intersection pipeline.
// No dependencies; every other file imports this package.
package si_pkg;

	localparam int COORD_WIDTH = 16;

	localparam int AW   = COORD_WIDTH + 1;
	localparam int MW   = 2 * COORD_WIDTH;
	localparam int CCW  = 2 * COORD_WIDTH + 2;
	localparam int PW   = 2 * COORD_WIDTH + 1;
	localparam int DPW  = 2 * COORD_WIDTH + 2;
	localparam int SW   = 2 * COORD_WIDTH + 3;
	localparam int DW   = 2 * COORD_WIDTH + 3;
	localparam int NPW  = AW + CCW;
	localparam int NW   = NPW + 1;
	localparam int NMW  = NW;
	localparam int QW   = COORD_WIDTH + 1;
	localparam int DIV_LAT = QW + 1;
	localparam int FRONT_LAT = 3;
	localparam int TOTAL_LAT = FRONT_LAT + 3 + DIV_LAT;

	localparam logic [1:0] ST_NONE      = 2'd0;
	localparam logic [1:0] ST_HIT       = 2'd1;
	localparam logic [1:0] ST_COLLINEAR = 2'd2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] first_start_x;
		logic signed [COORD_WIDTH-1:0] first_start_y;
		logic signed [COORD_WIDTH-1:0] first_end_x;
		logic signed [COORD_WIDTH-1:0] first_end_y;
		logic signed [COORD_WIDTH-1:0] second_start_x;
		logic signed [COORD_WIDTH-1:0] second_start_y;
		logic signed [COORD_WIDTH-1:0] second_end_x;
		logic signed [COORD_WIDTH-1:0] second_end_y;
	} seg_t;

	typedef struct packed {
		logic [1:0]                    status;
		logic signed [COORD_WIDTH-1:0] cross_x;
		logic signed [COORD_WIDTH-1:0] cross_y;
	} res_t;

	typedef struct packed {
		logic signed [SW-1:0]  s3;
		logic signed [SW-1:0]  s4;
		logic signed [SW-1:0]  s1;
		logic signed [SW-1:0]  s2;
		logic signed [DW-1:0]  d;
		logic signed [NPW-1:0] b1c2;
		logic signed [NPW-1:0] b2c1;
		logic signed [NPW-1:0] a2c1;
		logic signed [NPW-1:0] a1c2;
	} front_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] status;
		logic       negx;
		logic       negy;
	} side_t;

endpackage

FILE: rtl/segment_intersection.sv
// Top level of the segment intersection pipeline: front end, status and
// rounding stages, two dividers and the result register. Depends on si_pkg.
//
//   channel | ports              | beat taken when
//   input   | start, busy, seg   | start high and busy low at a rising edge
//   result  | done, res          | done high for one cycle
//
// One pair enters every cycle; busy stays low.
// Each result passes the front end, the status and rounding stages, the dividers
// (one quotient bit per stage) and the result register after its start beat.
// Reset clears only the valid bits; no result follows reset without a start.
// The receiver cannot stall, so the pipeline always advances.
module segment_intersection import si_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  seg_t seg,
	output logic done,
	output res_t res
);

	localparam logic [QW-1:0] HI_MAG = QW'((1 << (COORD_WIDTH - 1)) - 1);
	localparam logic [QW-1:0] LO_MAG = QW'(1 << (COORD_WIDTH - 1));
	localparam logic [COORD_WIDTH-1:0] HI_VAL = COORD_WIDTH'((1 << (COORD_WIDTH - 1)) - 1);
	localparam logic [COORD_WIDTH-1:0] LO_VAL = COORD_WIDTH'(1 << (COORD_WIDTH - 1));

	logic   fr_valid;
	front_t fr;

	logic               v_s4;
	logic [1:0]         st_s4;
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic [DW-1:0]      dmag_s4;
	logic               dneg_s4;

	logic [NMW-1:0] nmx_s5, nmy_s5;
	logic [DW-1:0]  dmag_s5;
	side_t          side_s [0:DIV_LAT];

	logic           ovfx, ovfy;
	logic [QW-1:0]  qx, qy;
	logic           rej1, rej2;
	side_t          side_out;
	res_t           res_d;

	assign busy = 1'b0;

	si_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.seg       (seg),
		.out_valid (fr_valid),
		.fr        (fr)
	);

	// Strictly one side: both values nonzero with the same sign.
	assign rej1 = (fr.s3 != '0) && (fr.s4 != '0) && (fr.s3[SW-1] == fr.s4[SW-1]);
	assign rej2 = (fr.s1 != '0) && (fr.s2 != '0) && (fr.s1[SW-1] == fr.s2[SW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			for (int i = 0; i <= DIV_LAT; i++) side_s[i].valid <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= fr_valid;
			side_s[0].valid  <= v_s4;
			side_s[0].status <= st_s4;
			side_s[0].negx   <= nx_s4[NW-1] ^ dneg_s4;
			side_s[0].negy   <= ny_s4[NW-1] ^ dneg_s4;
			for (int i = 1; i <= DIV_LAT; i++) side_s[i] <= side_s[i-1];
			done <= side_out.valid;
		end
	end

	always_ff @(posedge clk) begin
		// Stage 4: status and signed numerators.
		if (rej1 || rej2)
			st_s4 <= ST_NONE;
		else if (fr.d == '0)
			st_s4 <= ST_COLLINEAR;
		else
			st_s4 <= ST_HIT;
		nx_s4   <= NW'(fr.b1c2) - NW'(fr.b2c1);
		ny_s4   <= NW'(fr.a2c1) - NW'(fr.a1c2);
		dneg_s4 <= fr.d[DW-1];
		dmag_s4 <= fr.d[DW-1] ? DW'(-fr.d) : DW'(fr.d);

		// Stage 5: magnitudes with half the divisor added for rounding.
		nmx_s5  <= (nx_s4[NW-1] ? NMW'(-nx_s4) : NMW'(nx_s4)) + NMW'(dmag_s4 >> 1);
		nmy_s5  <= (ny_s4[NW-1] ? NMW'(-ny_s4) : NMW'(ny_s4)) + NMW'(dmag_s4 >> 1);
		dmag_s5 <= dmag_s4;

		res <= res_d;
	end

	si_div u_div_x (.clk(clk), .num(nmx_s5), .den(dmag_s5), .ovf(ovfx), .quo(qx));
	si_div u_div_y (.clk(clk), .num(nmy_s5), .den(dmag_s5), .ovf(ovfy), .quo(qy));

	assign side_out = side_s[DIV_LAT];

	function automatic logic [COORD_WIDTH-1:0] sat(input logic neg, input logic ovf,
			input logic [QW-1:0] q);
		logic [QW-1:0] nq;
		nq = ~q + QW'(1);
		if (neg)
			return (ovf || q > LO_MAG) ? LO_VAL : nq[COORD_WIDTH-1:0];
		else
			return (ovf || q > HI_MAG) ? HI_VAL : q[COORD_WIDTH-1:0];
	endfunction

	always_comb begin
		res_d.status  = side_out.status;
		res_d.cross_x = '0;
		res_d.cross_y = '0;
		if (side_out.status == ST_HIT) begin
			res_d.cross_x = sat(side_out.negx, ovfx, qx);
			res_d.cross_y = sat(side_out.negy, ovfy, qy);
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##TOTAL_LAT done)
		else $error("result missing after fixed latency");

	a_zero_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status != ST_HIT |-> res.cross_x == '0 && res.cross_y == '0)
		else $error("coordinates nonzero without a hit");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.status == ST_NONE || res.status == ST_HIT ||
			res.status == ST_COLLINEAR)
		else $error("undefined status code");

endmodule

FILE: rtl/si_front.sv
// Three-stage front end: line coefficients, side-test values, determinant
// and numerator products. Depends on si_pkg.
module si_front import si_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  seg_t   seg,
	output logic   out_valid,
	output front_t fr
);

	logic signed [COORD_WIDTH-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
	logic v_s1, v_s2, v_s3;

	logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [MW-1:0] m21_s1, m12_s1, m43_s1, m34_s1;
	logic signed [COORD_WIDTH-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;

	logic signed [AW-1:0]  a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [CCW-1:0] c1_s2, c2_s2;
	logic signed [PW-1:0]  p3a_s2, p3b_s2, p4a_s2, p4b_s2, p1a_s2, p1b_s2, p2a_s2, p2b_s2;
	logic signed [DPW-1:0] da_s2, db_s2;

	assign x1 = $signed(seg.first_start_x);
	assign y1 = $signed(seg.first_start_y);
	assign x2 = $signed(seg.first_end_x);
	assign y2 = $signed(seg.first_end_y);
	assign x3 = $signed(seg.second_start_x);
	assign y3 = $signed(seg.second_start_y);
	assign x4 = $signed(seg.second_end_x);
	assign y4 = $signed(seg.second_end_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		// Stage 1: coefficient differences and the products that make up c.
		a1_s1  <= AW'(y2) - AW'(y1);
		b1_s1  <= AW'(x1) - AW'(x2);
		a2_s1  <= AW'(y4) - AW'(y3);
		b2_s1  <= AW'(x3) - AW'(x4);
		m21_s1 <= x2 * y1;
		m12_s1 <= y2 * x1;
		m43_s1 <= x4 * y3;
		m34_s1 <= y4 * x3;
		x1_s1 <= x1; y1_s1 <= y1; x2_s1 <= x2; y2_s1 <= y2;
		x3_s1 <= x3; y3_s1 <= y3; x4_s1 <= x4; y4_s1 <= y4;

		// Stage 2: c terms, side-test products and determinant products.
		a1_s2  <= a1_s1; b1_s2 <= b1_s1; a2_s2 <= a2_s1; b2_s2 <= b2_s1;
		c1_s2  <= CCW'(m21_s1) - CCW'(m12_s1);
		c2_s2  <= CCW'(m43_s1) - CCW'(m34_s1);
		p3a_s2 <= a1_s1 * x3_s1;
		p3b_s2 <= b1_s1 * y3_s1;
		p4a_s2 <= a1_s1 * x4_s1;
		p4b_s2 <= b1_s1 * y4_s1;
		p1a_s2 <= a2_s1 * x1_s1;
		p1b_s2 <= b2_s1 * y1_s1;
		p2a_s2 <= a2_s1 * x2_s1;
		p2b_s2 <= b2_s1 * y2_s1;
		da_s2  <= a1_s1 * b2_s1;
		db_s2  <= a2_s1 * b1_s1;

		// Stage 3: side values, determinant and numerator products.
		fr.s3   <= SW'(p3a_s2) + SW'(p3b_s2) + SW'(c1_s2);
		fr.s4   <= SW'(p4a_s2) + SW'(p4b_s2) + SW'(c1_s2);
		fr.s1   <= SW'(p1a_s2) + SW'(p1b_s2) + SW'(c2_s2);
		fr.s2   <= SW'(p2a_s2) + SW'(p2b_s2) + SW'(c2_s2);
		fr.d    <= DW'(da_s2) - DW'(db_s2);
		fr.b1c2 <= b1_s2 * c2_s2;
		fr.b2c1 <= b2_s2 * c1_s2;
		fr.a2c1 <= a2_s2 * c1_s2;
		fr.a1c2 <= a1_s2 * c2_s2;
	end

	assign out_valid = v_s3;

endmodule

FILE: rtl/si_div.sv
// Pipelined restoring divider: one quotient bit per stage, plus an overflow
// flag for quotients that do not fit QW bits. Depends on si_pkg.
module si_div import si_pkg::*; (
	input  logic             clk,
	input  logic [NMW-1:0]   num,
	input  logic [DW-1:0]    den,
	output logic             ovf,
	output logic [QW-1:0]    quo
);

	logic [NMW-1:0] rem_s [0:QW];
	logic [DW-1:0]  den_s [0:QW];
	logic [QW-1:0]  quo_s [0:QW];
	logic           ovf_s [0:QW];

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= num >= (NMW'(den) << QW);
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [NMW-1:0] trial;
		logic           take;
		assign trial = NMW'(den_s[k-1]) << (QW - k);
		assign take  = rem_s[k-1] >= trial;
		always_ff @(posedge clk) begin
			rem_s[k] <= take ? rem_s[k-1] - trial : rem_s[k-1];
			den_s[k] <= den_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
			quo_s[k] <= quo_s[k-1] | (take ? (QW'(1) << (QW - k)) : '0);
		end
	end

	assign ovf = ovf_s[QW];
	assign quo = quo_s[QW];

endmodule

FILE: verif/segment_intersection_tb.sv
// Self-checking testbench for segment_intersection: directed corner pairs,
// then a random stream that leans toward crossing, collinear and parallel pairs.
// Depends on si_pkg and the segment_intersection top level.
module segment_intersection_tb;
	import si_pkg::*;

	localparam int N_RANDOM = 1030;
	localparam int QUIET_TAIL = 150;
	localparam int STALL_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	seg_t seg;
	logic done;
	res_t res;

	res_t expected_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_hit = 0;
	int n_none = 0;
	int n_coll = 0;
	int idle_cycles = 0;

	segment_intersection dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.seg(seg),
		.done(done),
		.res(res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit strictly_one_side(longint u, longint v);
		if (u == 0 || v == 0)
			return 1'b0;
		return (u < 0) == (v < 0);
	endfunction

	// Half of |den| is added to the magnitude, then the quotient truncates toward zero.
	function automatic logic signed [COORD_WIDTH-1:0] round_quotient(longint num, longint den);
		longint half;
		longint q;
		longint hi;
		longint lo;
		half = (den < 0 ? -den : den) / 2;
		q = (num < 0 ? num - half : num + half) / den;
		hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
		lo = -(longint'(1) <<< (COORD_WIDTH - 1));
		if (q > hi)
			q = hi;
		if (q < lo)
			q = lo;
		return q[COORD_WIDTH-1:0];
	endfunction

	function automatic res_t predict_crossing(seg_t s);
		longint x1, y1, x2, y2, x3, y3, x4, y4;
		longint a1, b1, c1, a2, b2, c2, d;
		res_t r;
		r = '0;
		r.status = ST_NONE;
		x1 = s.first_start_x;
		y1 = s.first_start_y;
		x2 = s.first_end_x;
		y2 = s.first_end_y;
		x3 = s.second_start_x;
		y3 = s.second_start_y;
		x4 = s.second_end_x;
		y4 = s.second_end_y;
		a1 = y2 - y1;
		b1 = x1 - x2;
		c1 = x2 * y1 - y2 * x1;
		if (strictly_one_side(a1 * x3 + b1 * y3 + c1, a1 * x4 + b1 * y4 + c1))
			return r;
		a2 = y4 - y3;
		b2 = x3 - x4;
		c2 = x4 * y3 - y4 * x3;
		if (strictly_one_side(a2 * x1 + b2 * y1 + c2, a2 * x2 + b2 * y2 + c2))
			return r;
		d = a1 * b2 - a2 * b1;
		if (d == 0) begin
			r.status = ST_COLLINEAR;
			return r;
		end
		r.status = ST_HIT;
		r.cross_x = round_quotient(b1 * c2 - b2 * c1, d);
		r.cross_y = round_quotient(a2 * c1 - a1 * c2, d);
		return r;
	endfunction

	function automatic seg_t make_pair(int x1, int y1, int x2, int y2,
			int x3, int y3, int x4, int y4);
		seg_t s;
		s.first_start_x = COORD_WIDTH'(x1);
		s.first_start_y = COORD_WIDTH'(y1);
		s.first_end_x = COORD_WIDTH'(x2);
		s.first_end_y = COORD_WIDTH'(y2);
		s.second_start_x = COORD_WIDTH'(x3);
		s.second_start_y = COORD_WIDTH'(y3);
		s.second_end_x = COORD_WIDTH'(x4);
		s.second_end_y = COORD_WIDTH'(y4);
		return s;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Every accepted beat is predicted here, so expectations follow the handshake.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_q.push_back(predict_crossing(seg));
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("results without a pending beat", 1, 0);
			end else begin
				want = expected_q.pop_front();
				if (res.status != want.status)
					report_mismatch("status", res.status, want.status);
				if (res.cross_x != want.cross_x)
					report_mismatch("cross_x", res.cross_x, want.cross_x);
				if (res.cross_y != want.cross_y)
					report_mismatch("cross_y", res.cross_y, want.cross_y);
				case (want.status)
					ST_HIT: n_hit++;
					ST_COLLINEAR: n_coll++;
					default: n_none++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Called just after a rising edge; returns just after the edge that took the beat.
	task automatic send_pair(seg_t s);
		start <= 1'b1;
		seg <= s;
		do
			@(posedge clk);
		while (busy);
		n_sent++;
	endtask

	task automatic maybe_pause(bit allowed);
		if (allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(posedge clk);
		end
	endtask

	function automatic int rand_coord(int scale);
		if (scale == 0)
			return $signed(16'($urandom_range(0, 65535)));
		return $urandom_range(0, 2 * scale) - scale;
	endfunction

	function automatic int pick_scale();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 8;
			2: return 300;
			default: return 12000;
		endcase
	endfunction

	task automatic test_directed();
		seg_t list[$];
		list.push_back(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
		list.push_back(make_pair(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768));
		list.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
		list.push_back(make_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767));
		list.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
		list.push_back(make_pair(0, 0, 3, 0, 1, -1, 2, 2));
		list.push_back(make_pair(0, 0, 3, 1, 1, -1, 2, 2));
		list.push_back(make_pair(0, 0, -3, -1, -1, 1, -2, -2));
		list.push_back(make_pair(0, 0, 1, 0, 0, 1, 1, 2));
		list.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 20));
		list.push_back(make_pair(0, 0, 10, 0, 20, -5, 20, 5));
		list.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 7));
		list.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 9));
		list.push_back(make_pair(0, 0, 10, 10, 2, 2, 20, 20));
		list.push_back(make_pair(0, 0, 10, 10, 20, 20, 30, 30));
		list.push_back(make_pair(0, 0, 10, 0, 0, 3, 10, 3));
		list.push_back(make_pair(4, 4, 4, 4, 0, 0, 9, 9));
		list.push_back(make_pair(4, 4, 4, 4, 0, 0, 9, 1));
		list.push_back(make_pair(0, 0, 9, 1, 4, 4, 4, 4));
		list.push_back(make_pair(7, 7, 7, 7, 7, 7, 7, 7));
		list.push_back(make_pair(0, 0, 2, 1, 1, 0, 0, 1));
		list.push_back(make_pair(0, 0, -2, -1, -1, 0, 0, -1));
		list.push_back(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
		list.push_back(make_pair(21845, -21846, -10923, 10922, -32768, -1, 32767, 0));
		foreach (list[i]) begin
			send_pair(list[i]);
			maybe_pause(1'b1);
		end
	endtask

	task automatic test_random_stream();
		seg_t s;
		res_t guess;
		int scale;
		int px, py, dx, dy, k;
		for (int i = 0; i < N_RANDOM; i++) begin
			k = $urandom_range(0, 9);
			scale = pick_scale();
			if (k <= 5) begin
				// Redraw a few times so most of these pairs cross or overlap.
				for (int t = 0; t < 8; t++) begin
					s = make_pair(rand_coord(scale), rand_coord(scale), rand_coord(scale),
						rand_coord(scale), rand_coord(scale), rand_coord(scale),
						rand_coord(scale), rand_coord(scale));
					guess = predict_crossing(s);
					if (guess.status != ST_NONE)
						break;
				end
			end else if (k <= 7) begin
				// Points on one line, or on a line shifted by a small offset.
				px = rand_coord(1000);
				py = rand_coord(1000);
				dx = rand_coord(100);
				dy = rand_coord(100);
				k = (k == 7) ? $urandom_range(0, 3) : 0;
				s = make_pair(px, py, px + 5 * dx, py + 5 * dy,
					px - 5 * dx + k, py - 5 * dy, px + $urandom_range(0, 10) * dx + k,
					py + $urandom_range(0, 10) * dy);
			end else begin
				s = seg_t'({$urandom, $urandom, $urandom, $urandom});
			end
			send_pair(s);
			maybe_pause(i < N_RANDOM - QUIET_TAIL);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		seg = '0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_stream();
		start <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (TOTAL_LAT + 8)
			@(posedge clk);
		$display("sent %0d segment pairs: %0d crossing, %0d collinear, %0d apart",
			n_sent, n_hit, n_coll, n_none);
		if (errors == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
